// File: rtl/core/ptw_pkg.sv
// Shared types and constants for the page table walker.
// Used by the store search unit and the walker top level; no dependencies.
package ptw_pkg;

  typedef logic [63:0] word_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_XLATED = 2'd0,
    STATUS_FAULT  = 2'd1,
    STATUS_STORED = 2'd2,
    STATUS_FULL   = 2'd3
  } status_t;

  // Operation codes
  localparam logic OP_STORE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Entry format: bits 51:12 hold the next frame, bit 0 is present
  localparam word_t FRAME_MASK  = 64'h000F_FFFF_FFFF_F000;
  localparam int    OFFSET_BITS = 12;
  localparam int    INDEX_BITS  = 9;
  localparam int    WALK_LEVELS = 4;

  // Lookup request from the sequencer to the store
  typedef struct packed {
    logic  start;
    word_t key;
  } lookup_req_t;

  // Lookup response: one-cycle done pulse
  typedef struct packed {
    logic  done;
    logic  hit;
    logic  full;
    word_t word;
  } lookup_rsp_t;

  // Word write into the slot chosen by the last lookup
  typedef struct packed {
    logic  en;
    word_t addr;
    word_t word;
  } store_wr_t;

endpackage

// File: rtl/core/ptw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ptw_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ptw_store.sv
// Associative word store: address/word pairs in a RAM, searched one slot per cycle.
// Depends on ptw_pkg and ptw_ram.
module ptw_store #(
  parameter int STORE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptw_pkg::lookup_req_t req,
  output ptw_pkg::lookup_rsp_t rsp,
  input  ptw_pkg::store_wr_t   wr
);
  import ptw_pkg::*;

  localparam int IW = $clog2(STORE_ENTRIES);
  localparam int CW = $clog2(STORE_ENTRIES + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_ENTRIES);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t          state;
  logic [CW-1:0]   slots_used;
  logic [CW-1:0]   issue_idx;
  logic            pend;
  logic [IW-1:0]   pend_idx;
  word_t           key;
  logic [IW-1:0]   slot_sel;
  logic            slot_new;
  logic [127:0]    rd_data;
  logic            hit_now;
  logic            issue_now;

  // Slot data: address in the upper half, word in the lower half
  ptw_ram #(
    .WIDTH(128),
    .DEPTH(STORE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(slot_sel),
    .wdata({wr.addr, wr.word}),
    .raddr(issue_idx[IW-1:0]),
    .rdata(rd_data)
  );

  // Compare the slot read last cycle; keep issuing while filled slots remain
  assign hit_now   = pend && (rd_data[127:64] == key);
  assign issue_now = issue_idx < slots_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slots_used <= '0;
      rsp.done   <= 1'b0;
      pend       <= 1'b0;
    end else begin
      rsp.done <= 1'b0;

      // Fill count grows when a write lands in a fresh slot
      if (wr.en && slot_new) begin
        slots_used <= slots_used + CW'(1);
      end

      case (state)
        S_IDLE: begin
          if (req.start) begin
            key       <= req.key;
            issue_idx <= '0;
            pend      <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend     <= issue_now;
          pend_idx <= issue_idx[IW-1:0];
          if (issue_now) begin
            issue_idx <= issue_idx + CW'(1);
          end
          if (hit_now) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b1;
            rsp.full <= (slots_used == DEPTH_C);
            rsp.word <= rd_data[63:0];
            slot_sel <= pend_idx;
            slot_new <= 1'b0;
            pend     <= 1'b0;
            state    <= S_IDLE;
          end else if (!pend && !issue_now) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b0;
            rsp.full <= (slots_used == DEPTH_C);
            rsp.word <= '0;
            slot_sel <= slots_used[IW-1:0];
            slot_new <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Fill count never passes the depth
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= DEPTH_C)
    else $error("fill count beyond store depth");

  // A write into a fresh slot advances the fill count by one
  a_used_step: assert property (@(posedge clk) disable iff (rst)
    wr.en && slot_new |=> slots_used == $past(slots_used) + CW'(1))
    else $error("fill count did not advance on new slot");

  // A lookup answers with a single pulse
  a_rsp_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("lookup response longer than one cycle");

endmodule

// File: rtl/core/four_level_page_table_walker.sv
// Four-level page table walker. A lookup scans the filled slots of the store; a
// store is one lookup and a write, a translation one lookup per level and a final
// offset add, one item at a time (busy meanwhile).
// The associative store scans one slot per cycle.
// Synchronous reset empties the store (fill count zero) and clears the root to 0.
// The done strobe lasts one cycle; the receiver cannot stall it.
module four_level_page_table_walker #(
  parameter int STORE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic [63:0]         word_address,
  input  logic [63:0]         word_value,
  input  logic [63:0]         lin_addr,
  output logic                done,
  output logic [63:0]         phys_addr,
  output ptw_pkg::status_t    status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [63:0]         root_table_address
);
  import ptw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_WALK_WAIT, S_FINAL, S_STORE_WAIT
  } state_t;

  localparam logic [1:0] LAST_LEVEL = 2'(WALK_LEVELS - 1);

  state_t                 state;
  word_t                  root_table;
  word_t                  la;
  word_t                  st_addr;
  word_t                  st_word;
  word_t                  table_addr;
  logic [1:0]             level;
  lookup_req_t            lk;
  lookup_rsp_t            rsp;
  store_wr_t              wr;
  logic [INDEX_BITS-1:0]  level_idx;
  word_t                  add_b;
  word_t                  sum;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  ptw_store #(
    .STORE_ENTRIES(STORE_ENTRIES)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .req(lk),
    .rsp(rsp),
    .wr (wr)
  );

  // Table index for the current level, top level first
  always_comb begin
    case (level)
      2'd0:    level_idx = la[47:39];
      2'd1:    level_idx = la[38:30];
      2'd2:    level_idx = la[29:21];
      default: level_idx = la[20:12];
    endcase
  end

  // Shared adder: entry address per level, page offset at the end
  assign add_b = (state == S_FINAL) ? {52'b0, la[OFFSET_BITS-1:0]}
                                    : {52'b0, level_idx, 3'b000};
  assign sum   = table_addr + add_b;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      lk.start   <= 1'b0;
      wr.en      <= 1'b0;
      root_table <= '0;
    end else begin
      done     <= 1'b0;
      lk.start <= 1'b0;
      wr.en    <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        root_table <= root_table_address;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            la         <= lin_addr;
            st_addr    <= word_address;
            st_word    <= word_value;
            table_addr <= root_table;
            level      <= 2'd0;
            if (op == OP_STORE) begin
              lk.start <= 1'b1;
              lk.key   <= word_address;
              state    <= S_STORE_WAIT;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          lk.start <= 1'b1;
          lk.key   <= sum;
          state    <= S_WALK_WAIT;
        end
        S_WALK_WAIT: begin
          if (rsp.done) begin
            // Missing or non-present entry faults the walk
            if (!rsp.hit || !rsp.word[0]) begin
              done      <= 1'b1;
              phys_addr <= '0;
              status    <= STATUS_FAULT;
              state     <= S_IDLE;
            end else begin
              table_addr <= rsp.word & FRAME_MASK;
              if (level == LAST_LEVEL) begin
                state <= S_FINAL;
              end else begin
                level <= level + 2'd1;
                state <= S_ISSUE;
              end
            end
          end
        end
        S_FINAL: begin
          done      <= 1'b1;
          phys_addr <= sum;
          status    <= STATUS_XLATED;
          state     <= S_IDLE;
        end
        S_STORE_WAIT: begin
          if (rsp.done) begin
            done      <= 1'b1;
            phys_addr <= '0;
            // Overwrite a held address, else take a fresh slot if any remain
            if (rsp.hit || !rsp.full) begin
              wr.en   <= 1'b1;
              wr.addr <= st_addr;
              wr.word <= st_word;
              status  <= STATUS_STORED;
            end else begin
              status <= STATUS_FULL;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // Only a successful translation carries an address
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    done && status != STATUS_XLATED |-> phys_addr == '0)
    else $error("nonzero address with non-translate status");

  // Lookup requests are single-cycle pulses
  a_lk_pulse: assert property (@(posedge clk) disable iff (rst)
    lk.start |=> !lk.start)
    else $error("lookup request longer than one cycle");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for four_level_page_table_walker: directed and random store and
// translate traffic, checked against a behavioral table walk over a sparse store.
// Depends on ptw_pkg and the walker RTL only.
module tb_top;
  import ptw_pkg::*;

  localparam int    STORE_ENTRIES = 64;
  localparam int    QUIET_LIMIT   = 4000;
  localparam int    TABLE_COUNT   = 4;
  localparam int    TABLE_FILL    = 6;
  localparam int    PHASE_ITEMS   = 180;
  localparam word_t ALL_ONES      = '1;
  localparam word_t PRESENT       = 64'h1;
  localparam word_t TOP_FRAME     = FRAME_MASK;  // highest frame an entry can name

  typedef struct packed {
    word_t   phys;
    status_t status;
  } walk_result_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  logic    op = OP_STORE;
  word_t   word_address = '0;
  word_t   word_value = '0;
  word_t   lin_addr = '0;
  logic    done;
  word_t   phys_addr;
  status_t status;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  word_t   root_table_address = '0;

  four_level_page_table_walker #(.STORE_ENTRIES(STORE_ENTRIES)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .word_address(word_address),
    .word_value(word_value),
    .lin_addr(lin_addr),
    .done(done),
    .phys_addr(phys_addr),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .root_table_address(root_table_address)
  );

  // Shadow of the store, the root and the results in flight
  word_t        store_addr [STORE_ENTRIES];
  word_t        store_word [STORE_ENTRIES];
  int           store_used = 0;
  word_t        walk_root = '0;
  walk_result_t pending_results [$];
  walk_result_t oldest;
  int           errors = 0;
  int           sender_idle_pct = 0;
  int           quiet_cycles = 0;

  // Page tables used by the random traffic: base and populated indexes
  word_t        table_base [TABLE_COUNT];
  logic [8:0]   entry_idx [TABLE_COUNT][TABLE_FILL];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t entry_addr(word_t tbl, logic [8:0] idx);
    return tbl + {52'b0, idx, 3'b000};
  endfunction

  function automatic word_t make_la(logic [15:0] hi, logic [8:0] i1, logic [8:0] i2,
                                    logic [8:0] i3, logic [8:0] i4, logic [11:0] off);
    return {hi, i1, i2, i3, i4, off};
  endfunction

  function automatic int slot_of(word_t addr);
    for (int i = 0; i < store_used; i++)
      if (store_addr[i] == addr) return i;
    return -1;
  endfunction

  // Unwritten addresses read as zero (not present)
  function automatic word_t read_word(word_t addr);
    int s;
    s = slot_of(addr);
    return (s < 0) ? '0 : store_word[s];
  endfunction

  // Expected result of one item; updates the shadow store
  function automatic walk_result_t apply_item(logic op_code, word_t waddr, word_t wval,
                                              word_t laddr);
    walk_result_t r;
    word_t        tbl;
    word_t        entry;
    int           s;
    int           sh;
    r.phys = '0;
    if (op_code == OP_STORE) begin
      s = slot_of(waddr);
      if (s >= 0) begin
        store_word[s] = wval;
        r.status = STATUS_STORED;
      end else if (store_used < STORE_ENTRIES) begin
        store_addr[store_used] = waddr;
        store_word[store_used] = wval;
        store_used++;
        r.status = STATUS_STORED;
      end else begin
        r.status = STATUS_FULL;
      end
    end else begin
      tbl = walk_root;
      r.status = STATUS_XLATED;
      for (int lvl = 0; lvl < WALK_LEVELS; lvl++) begin
        sh = OFFSET_BITS + INDEX_BITS * (WALK_LEVELS - 1 - lvl);
        entry = read_word(entry_addr(tbl, laddr[sh +: INDEX_BITS]));
        if (!entry[0]) begin
          r.status = STATUS_FAULT;
          break;
        end
        tbl = entry & FRAME_MASK;
      end
      if (r.status == STATUS_XLATED) r.phys = tbl + {52'b0, laddr[OFFSET_BITS-1:0]};
    end
    return r;
  endfunction

  // Entry with random flags, mostly present and mostly pointing at a known table
  function automatic word_t make_entry();
    word_t v;
    v = rand_word();
    if ($urandom_range(0, 9) != 0)
      v = (v & ~FRAME_MASK) | table_base[$urandom_range(1, TABLE_COUNT - 1)];
    v[0] = ($urandom_range(0, 9) != 0);
    return v;
  endfunction

  // Logical address that follows populated entries as far as the tables allow
  function automatic word_t walk_address();
    word_t la;
    word_t tbl;
    word_t entry;
    int    sh;
    la = rand_word();
    tbl = walk_root;
    for (int lvl = 0; lvl < WALK_LEVELS; lvl++) begin
      sh = OFFSET_BITS + INDEX_BITS * (WALK_LEVELS - 1 - lvl);
      for (int k = 0; k < TABLE_COUNT; k++)
        if (table_base[k] == tbl && $urandom_range(0, 19) != 0)
          la[sh +: INDEX_BITS] = entry_idx[k][$urandom_range(0, TABLE_FILL - 1)];
      entry = read_word(entry_addr(tbl, la[sh +: INDEX_BITS]));
      if (!entry[0]) break;
      tbl = entry & FRAME_MASK;
    end
    return la;
  endfunction

  // One command transfer; start stays high between back-to-back items
  task automatic send_cmd(input logic op_code, input word_t waddr, input word_t wval,
                          input word_t laddr);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 8))
        @(posedge clk);
    end
    start <= 1'b1;
    op <= op_code;
    word_address <= waddr;
    word_value <= wval;
    lin_addr <= laddr;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_item(op_code, waddr, wval, laddr));
  endtask

  task automatic drain_results(input int settle);
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Root register write, only with the walker idle
  task automatic write_root(input word_t value);
    drain_results(4);
    cfg_valid <= 1'b1;
    root_table_address <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    walk_root = value;
  endtask

  task automatic test_empty_store();
    // reset root, nothing stored: the first level read misses
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(), rand_word());
  endtask

  task automatic test_wrapped_root();
    write_root(ALL_ONES);
    // root + 8*511 wraps around zero; entry with every flag bit set
    send_cmd(OP_STORE, entry_addr(ALL_ONES, '1), ALL_ONES, rand_word());
    // top frame points back at itself through index 0
    send_cmd(OP_STORE, TOP_FRAME, TOP_FRAME | PRESENT, rand_word());
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(), make_la('1, '1, '0, '0, '0, '1));
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(), make_la('0, '1, '0, '0, '0, '0));
    // a missing entry at each level in turn
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(),
             make_la(16'($urandom), '0, 9'($urandom), 9'($urandom), 9'($urandom),
                     12'($urandom)));
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(),
             make_la(16'($urandom), '1, 9'd1, '0, '0, 12'($urandom)));
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(),
             make_la(16'($urandom), '1, '0, 9'd5, '0, 12'($urandom)));
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(),
             make_la(16'($urandom), '1, '0, '0, 9'd5, 12'($urandom)));
  endtask

  task automatic test_entry_flags();
    // present bit clear, all else set
    send_cmd(OP_STORE, entry_addr(TOP_FRAME, 9'd7), ALL_ONES ^ PRESENT, rand_word());
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(),
             make_la(16'($urandom), '1, '0, '0, 9'd7, 12'($urandom)));
    // overwrite in place: present, frame zero
    send_cmd(OP_STORE, entry_addr(TOP_FRAME, 9'd7), PRESENT, rand_word());
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(), make_la('0, '1, '0, '0, 9'd7, 12'h123));
    // flag bits ignored: all-ones entry names the top frame
    send_cmd(OP_STORE, entry_addr(TOP_FRAME, 9'd8), ALL_ONES, rand_word());
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(),
             make_la(16'($urandom), '1, '0, '0, 9'd8, 12'($urandom)));
    // top address now holds a zero word
    send_cmd(OP_STORE, ALL_ONES, '0, rand_word());
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(),
             make_la(16'($urandom), '0, 9'($urandom), 9'($urandom), 9'($urandom),
                     12'($urandom)));
  endtask

  task automatic test_zero_root();
    write_root('0);
    send_cmd(OP_STORE, '0, TOP_FRAME | PRESENT, rand_word());
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(), '0);
    send_cmd(OP_TRANSLATE, rand_word(), rand_word(), ALL_ONES);
  endtask

  // Populate a few tables; base 0 is only ever a root, so it may be unaligned
  task automatic test_table_build();
    table_base[0] = rand_word();
    for (int k = 1; k < TABLE_COUNT; k++) table_base[k] = rand_word() & FRAME_MASK;
    for (int k = 0; k < TABLE_COUNT; k++)
      for (int j = 0; j < TABLE_FILL; j++) begin
        entry_idx[k][j] = 9'($urandom_range(0, (1 << INDEX_BITS) - 1));
        send_cmd(OP_STORE, entry_addr(table_base[k], entry_idx[k][j]), make_entry(),
                 rand_word());
      end
  endtask

  task automatic test_random_traffic(input int idle_pct, input word_t root);
    int pick;
    int k;
    write_root(root);
    sender_idle_pct = idle_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, TABLE_COUNT - 1);
      if (pick < 30) begin
        // rewrite a table entry
        send_cmd(OP_STORE, entry_addr(table_base[k],
                 entry_idx[k][$urandom_range(0, TABLE_FILL - 1)]), make_entry(), rand_word());
      end else if (pick < 34) begin
        // new address: takes a slot, or is dropped once the store is full
        send_cmd(OP_STORE, rand_word(), rand_word(), rand_word());
      end else if (pick < 37) begin
        send_cmd(OP_STORE, store_addr[$urandom_range(0, store_used - 1)], rand_word(),
                 rand_word());
      end else if (pick < 90) begin
        send_cmd(OP_TRANSLATE, rand_word(), rand_word(), walk_address());
      end else begin
        send_cmd(OP_TRANSLATE, rand_word(), rand_word(), rand_word());
      end
    end
  endtask

  task automatic test_store_full();
    while (store_used < STORE_ENTRIES) send_cmd(OP_STORE, rand_word(), rand_word(), rand_word());
    // new addresses are dropped, held ones still take writes
    repeat (3) send_cmd(OP_STORE, rand_word(), rand_word(), rand_word());
    send_cmd(OP_STORE, store_addr[STORE_ENTRIES - 1], rand_word(), rand_word());
    send_cmd(OP_STORE, entry_addr(table_base[1], entry_idx[1][0]), make_entry(), rand_word());
    repeat (4) send_cmd(OP_TRANSLATE, rand_word(), rand_word(), walk_address());
  endtask

  // Result checker: every done pulse is a transfer
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: phys_addr %h status %0d",
               phys_addr, status);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (phys_addr !== oldest.phys) begin
          $error("phys_addr: expected %h, got %h", oldest.phys, phys_addr);
          errors++;
        end
        if (status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 21;
    test_empty_store();
    test_wrapped_root();
    test_entry_flags();
    test_zero_root();
    test_table_build();
    test_random_traffic(21, table_base[0]);
    test_random_traffic(48, table_base[1]);
    test_random_traffic(0, table_base[2]);
    test_store_full();
    drain_results(16);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
